// ===== sv/hxp_pkg.sv =====
// Shared types and constants for the hi-res XOR pixel plotter.
package hxp_pkg;

   localparam int unsigned FB_AW    = 13;
   localparam int unsigned FB_DEPTH = 8192;

   localparam logic [13:0] FB_BASE   = 14'h2000;
   localparam logic [7:0]  ROWS      = 8'd192;
   localparam logic [8:0]  DIV7_MUL  = 9'd293;  // x * 293 >> 11 == x / 7 for x < 256
   localparam int unsigned DIV7_SHIFT = 11;
   localparam logic [6:0]  THIRD_OFS = 7'd40;   // 0x28 per block of 64 rows

   // One slot table entry: frame buffer byte offset and pixel bit within it.
   typedef struct packed {
      logic [FB_AW-1:0] offset;
      logic [2:0]       bit_sel;
   } slot_entry_type;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_LOOKUP = 5'b00100,
      ST_ERASE  = 5'b01000,
      ST_DRAW   = 5'b10000
   } state_type;

   function automatic logic [7:0] bit_mask(input logic [2:0] sel);
      bit_mask = 8'd1 << sel;
   endfunction

endpackage

// ===== sv/hires_xor_pixel_plotter.sv =====
// Top level of the hi-res XOR pixel plotter: slot table, frame buffer and sequencer.
//
//   channel   direction  handshake                 payload
//   request   in         start & !busy             req_slot, req_pos_x, req_pos_y
//   response  out        rsp_valid (one cycle)     rsp_write_address, rsp_write_data,
//                                                  rsp_last_write
//
// A request for a slot already placed passes through accept, slot lookup, erase write
// and draw write before the next possible accept; a first placement skips the erase
// write; a request with an out-of-range slot or row is dropped in its accept cycle.
// Each write is a read-modify-write through one frame buffer memory with a registered
// read, preceded by a slot table read.
// After reset the block sweeps zeros through all 8192 frame buffer bytes, one a cycle,
// with busy high; slot placement bits clear at once.
// The receiver cannot stall: each response word is shown for exactly one cycle.
module hires_xor_pixel_plotter
   import hxp_pkg::*;
#(
   parameter int SLOT_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_slot,
   input  logic [7:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   output logic        rsp_valid,
   output logic [13:0] rsp_write_address,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_last_write
);

   localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int ENTRY_W = $bits(slot_entry_type);

   state_type state_ff, state_in;

   logic [FB_AW-1:0]      clr_addr_ff, clr_addr_in;
   logic [SLOT_COUNT-1:0] placed_ff, placed_in;
   logic [SLOT_AW-1:0]    slot_idx_ff, slot_idx_in;
   slot_entry_type        new_ff, new_in;
   logic [7:0]            erase_data_ff, erase_data_in;
   logic                  fwd_ff, fwd_in;

   // request decode: row base plus x / 7, bit x % 7
   logic              req_ok;
   logic [16:0]       div_prod;
   logic [5:0]        div_q;
   logic [8:0]        div_q7;
   logic [2:0]        div_r;
   logic [6:0]        col;
   slot_entry_type    req_entry;

   // memory ports
   logic                  slot_rd_en;
   logic                  slot_wr_en;
   slot_entry_type        slot_rd;
   logic [ENTRY_W-1:0]    slot_rd_bits;
   logic                  fb_wr_en;
   logic [FB_AW-1:0]      fb_wr_addr;
   logic [7:0]            fb_wr_data;
   logic                  fb_rd_en;
   logic [FB_AW-1:0]      fb_rd_addr;
   logic [7:0]            fb_rd_data;

   logic [7:0]            erase_val;
   logic [7:0]            draw_val;

   assign req_ok   = (int'(req_slot) < SLOT_COUNT) && (req_pos_y < ROWS);
   assign div_prod = 17'(req_pos_x) * 17'(DIV7_MUL);
   assign div_q    = div_prod[16:DIV7_SHIFT];
   assign div_q7   = {div_q, 3'b000} - {3'b000, div_q};
   assign div_r    = 3'(9'(req_pos_x) - div_q7);
   assign col      = 7'(div_q) + 7'(req_pos_y[7:6]) * THIRD_OFS;

   assign req_entry.offset  = {req_pos_y[2:0], req_pos_y[5:3], col};
   assign req_entry.bit_sel = div_r;

   assign slot_rd   = slot_entry_type'(slot_rd_bits);
   assign erase_val = fb_rd_data ^ bit_mask(slot_rd.bit_sel);
   assign draw_val  = (fwd_ff ? erase_data_ff : fb_rd_data) ^ bit_mask(new_ff.bit_sel);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      placed_in     = placed_ff;
      slot_idx_in   = slot_idx_ff;
      new_in        = new_ff;
      erase_data_in = erase_data_ff;
      fwd_in        = fwd_ff;

      slot_rd_en = 1'b0;
      slot_wr_en = 1'b0;
      fb_wr_en   = 1'b0;
      fb_wr_addr = clr_addr_ff;
      fb_wr_data = '0;
      fb_rd_en   = 1'b0;
      fb_rd_addr = new_ff.offset;

      busy              = 1'b1;
      rsp_valid         = 1'b0;
      rsp_write_address = FB_BASE | {1'b0, new_ff.offset};
      rsp_write_data    = draw_val;
      rsp_last_write    = 1'b1;

      case (state_ff)
         ST_CLEAR: begin
            // sweep zeros over the whole frame buffer
            fb_wr_en    = 1'b1;
            clr_addr_in = clr_addr_ff + FB_AW'(1);
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start && req_ok) begin
               // latch the decoded place and fetch the slot's old one
               slot_idx_in = SLOT_AW'(req_slot);
               new_in      = req_entry;
               slot_rd_en  = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // store the new place now; the old one is held on the read port
            slot_wr_en = 1'b1;
            placed_in[slot_idx_ff] = 1'b1;
            fwd_in     = 1'b0;
            fb_rd_en   = 1'b1;
            if (placed_ff[slot_idx_ff]) begin
               fb_rd_addr = slot_rd.offset;
               state_in   = ST_ERASE;
            end else begin
               state_in   = ST_DRAW;
            end
         end
         ST_ERASE: begin
            // write back the erased byte and read the draw byte;
            // forward when both land on the same byte
            fb_wr_en          = 1'b1;
            fb_wr_addr        = slot_rd.offset;
            fb_wr_data        = erase_val;
            fb_rd_en          = 1'b1;
            erase_data_in     = erase_val;
            fwd_in            = (slot_rd.offset == new_ff.offset);
            rsp_valid         = 1'b1;
            rsp_write_address = FB_BASE | {1'b0, slot_rd.offset};
            rsp_write_data    = erase_val;
            rsp_last_write    = 1'b0;
            state_in          = ST_DRAW;
         end
         ST_DRAW: begin
            fb_wr_en   = 1'b1;
            fb_wr_addr = new_ff.offset;
            fb_wr_data = draw_val;
            rsp_valid  = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         placed_ff   <= '0;
         fwd_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         placed_ff   <= placed_in;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_idx_ff   <= slot_idx_in;
      new_ff        <= new_in;
      erase_data_ff <= erase_data_in;
   end

   hxp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_idx_ff),
      .wr_data (new_ff),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_idx_in),
      .rd_data (slot_rd_bits)
   );

   hxp_ram #(
      .WIDTH (8),
      .DEPTH (FB_DEPTH)
   ) u_fb_ram (
      .clock   (clock),
      .wr_en   (fb_wr_en),
      .wr_addr (fb_wr_addr),
      .wr_data (fb_wr_data),
      .rd_en   (fb_rd_en),
      .rd_addr (fb_rd_addr),
      .rd_data (fb_rd_data)
   );

endmodule

// ===== sv/hxp_ram.sv =====
// Generic simple dual-port RAM with registered read.
module hxp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/hxp_checker.sv =====
// Port-level checker for the hi-res XOR pixel plotter, bound to the top level.
module hxp_checker
   import hxp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [3:0]  req_slot,
   input logic [7:0]  req_pos_x,
   input logic [7:0]  req_pos_y,
   input logic        rsp_valid,
   input logic [13:0] rsp_write_address,
   input logic [7:0]  rsp_write_data,
   input logic        rsp_last_write
);

   // words only come out while a request is in flight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response word while idle");

   // an erase word is always followed at once by its draw word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_write |=> rsp_valid && rsp_last_write)
      else $error("erase word not followed by draw word");

   // the draw word ends the run and frees the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_write |=> !busy && !rsp_valid)
      else $error("block still busy after draw word");

   // a row off the screen is dropped without any word
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_pos_y >= ROWS) |=> !busy && !rsp_valid)
      else $error("off-screen request not dropped");

endmodule

bind hires_xor_pixel_plotter hxp_checker u_hxp_checker (.*);
